@@ sv/countdown_timer_controller_macros.svh @@
// Assertion macros shared by the countdown timer controller RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef COUNTDOWN_TIMER_CONTROLLER_MACROS_SVH
`define COUNTDOWN_TIMER_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CTC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("countdown timer check failed");

// Next-cycle implication, disabled during reset
`define CTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("countdown timer check failed");

`endif

@@ sv/ctc_pkg.sv @@
// Shared types and constants of the countdown timer controller.
// Depends on nothing; used by ctc_step and countdown_timer_controller.
package ctc_pkg;

    localparam int unsigned STEP_W   = 12;
    localparam int unsigned HOLD_W   = 8;
    localparam int unsigned ACT_W    = 3;
    localparam int unsigned SUB_W    = 4;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned SHOWN_W  = 32;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned IN_W     = 8;
    localparam int unsigned OUT_W    = 40;
    localparam int unsigned SET_LIMIT = 59999;

    // Configuration register indexes
    localparam logic CFG_STEP = 1'b0;
    localparam logic CFG_HOLD = 1'b1;

    // Event codes
    localparam logic [ACT_W-1:0] ACT_INC   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DEC   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_START = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ABORT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TICK  = 3'd4;

    localparam logic [SUB_W-1:0] SUB_BEEP = 4'd5;
    localparam logic [SUB_W-1:0] SUB_SEC  = 4'd10;

    // Event status codes
    localparam logic [STAT_W-1:0] ST_IGN  = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE = 2'd1;
    localparam logic [STAT_W-1:0] ST_MOVE = 2'd2;

    // Reported mode codes
    localparam logic [MODE_W-1:0] MC_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] MC_SET   = 3'd1;
    localparam logic [MODE_W-1:0] MC_COUNT = 3'd2;
    localparam logic [MODE_W-1:0] MC_PAUSE = 3'd3;
    localparam logic [MODE_W-1:0] MC_STAT  = 3'd4;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_SET   = 5'b00010,
        MODE_COUNT = 5'b00100,
        MODE_PAUSE = 5'b01000,
        MODE_STAT  = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              beep;
        logic [STAT_W-1:0] status;
    } t_result;

    function automatic logic [MODE_W-1:0] mode_code(input t_mode m);
        logic [MODE_W-1:0] c;
        case (m)
            MODE_IDLE:  c = MC_IDLE;
            MODE_SET:   c = MC_SET;
            MODE_COUNT: c = MC_COUNT;
            MODE_PAUSE: c = MC_PAUSE;
            MODE_STAT:  c = MC_STAT;
            default:    c = MC_IDLE;
        endcase
        return c;
    endfunction

endpackage

@@ sv/ctc_step.sv @@
// Next-state and result logic of the countdown timer for one event word.
// Depends on ctc_pkg; instantiated by countdown_timer_controller.
module ctc_step #(
    parameter int TIME_BITS = 16
) (
    input  ctc_pkg::t_mode                  i_mode,
    input  logic [TIME_BITS-1:0]            i_set_time,
    input  logic [TIME_BITS-1:0]            i_elapsed,
    input  logic [31:0]                     i_total,
    input  logic [ctc_pkg::HOLD_W-1:0]      i_stat_cnt,
    input  logic [ctc_pkg::ACT_W-1:0]       i_action,
    input  logic [ctc_pkg::SUB_W-1:0]       i_subsecond,
    input  logic [ctc_pkg::STEP_W-1:0]      i_step,
    input  logic [ctc_pkg::HOLD_W-1:0]      i_hold,
    output ctc_pkg::t_mode                  o_mode,
    output logic [TIME_BITS-1:0]            o_set_time,
    output logic [TIME_BITS-1:0]            o_elapsed,
    output logic [31:0]                     o_total,
    output logic [ctc_pkg::HOLD_W-1:0]      o_stat_cnt,
    output logic [ctc_pkg::SHOWN_W-1:0]     o_shown,
    output ctc_pkg::t_result                o_res
);
    import ctc_pkg::*;

    localparam int SW = ((TIME_BITS > STEP_W) ? TIME_BITS : STEP_W) + 1;
    localparam logic [63:0] MASK64 = (64'd1 << TIME_BITS) - 64'd1;
    localparam logic [TIME_BITS-1:0] TIME_MAX =
        (MASK64 < 64'(SET_LIMIT)) ? MASK64[TIME_BITS-1:0] : TIME_BITS'(SET_LIMIT);

    logic [STEP_W-1:0]    step;
    logic [SW-1:0]        sum;
    logic [TIME_BITS-1:0] set_inc;
    logic                 dec_ok;
    logic [SW-1:0]        diff;
    logic [TIME_BITS-1:0] set_tick;
    logic [TIME_BITS-1:0] el_tick;
    logic [TIME_BITS-1:0] el_leave;
    logic [32:0]          tot_sum;
    logic [31:0]          tot_leave;
    logic [HOLD_W-1:0]    cnt_inc;

    always_comb begin
        // zero step acts as one second
        step    = (i_step == '0) ? STEP_W'(1) : i_step;
        sum     = SW'(i_set_time) + SW'(step);
        set_inc = (sum > SW'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];
        dec_ok  = SW'(i_set_time) >= SW'(step);
        diff    = SW'(i_set_time) - SW'(step);

        set_tick = (i_set_time != '0) ? i_set_time - TIME_BITS'(1) : i_set_time;
        el_tick  = (i_elapsed != '1) ? i_elapsed + TIME_BITS'(1) : i_elapsed;

        // tick at the second boundary leaves countdown with the bumped count
        el_leave  = (i_action == ACT_TICK) ? el_tick : i_elapsed;
        tot_sum   = {1'b0, i_total} + 33'(el_leave);
        tot_leave = tot_sum[32] ? '1 : tot_sum[31:0];
        cnt_inc   = i_stat_cnt + HOLD_W'(1);
    end

    always_comb begin
        o_mode     = i_mode;
        o_set_time = i_set_time;
        o_elapsed  = i_elapsed;
        o_total    = i_total;
        o_stat_cnt = i_stat_cnt;
        o_res.beep   = 1'b0;
        o_res.status = ST_IGN;

        case (i_mode)
            MODE_IDLE: begin
                if (i_action == ACT_INC) begin
                    o_set_time   = set_inc;
                    o_mode       = MODE_SET;
                    o_res.status = ST_MOVE;
                end else if (i_action == ACT_START) begin
                    o_mode       = MODE_STAT;
                    o_res.status = ST_MOVE;
                end else if (i_action == ACT_TICK && i_subsecond == SUB_BEEP) begin
                    o_res.beep   = 1'b1;
                    o_res.status = ST_DONE;
                end
            end
            MODE_SET: begin
                if (i_action == ACT_INC) begin
                    o_set_time   = set_inc;
                    o_res.status = ST_DONE;
                end else if (i_action == ACT_DEC) begin
                    if (dec_ok) begin
                        o_set_time   = diff[TIME_BITS-1:0];
                        o_res.status = ST_DONE;
                    end
                end else if (i_action == ACT_START) begin
                    if (dec_ok) begin
                        o_mode       = MODE_COUNT;
                        o_res.status = ST_MOVE;
                    end
                end else if (i_action == ACT_ABORT) begin
                    o_mode       = MODE_IDLE;
                    o_set_time   = '0;
                    o_elapsed    = '0;
                    o_res.status = ST_MOVE;
                end
            end
            MODE_COUNT: begin
                if (i_action == ACT_TICK) begin
                    if (i_subsecond == SUB_SEC) begin
                        if (set_tick == '0) begin
                            o_total      = tot_leave;
                            o_mode       = MODE_IDLE;
                            o_set_time   = '0;
                            o_elapsed    = '0;
                            o_res.status = ST_MOVE;
                        end else begin
                            o_set_time   = set_tick;
                            o_elapsed    = el_tick;
                            o_res.status = ST_DONE;
                        end
                    end
                end else if (i_action == ACT_START) begin
                    o_total      = tot_leave;
                    o_elapsed    = '0;
                    o_mode       = MODE_PAUSE;
                    o_res.status = ST_MOVE;
                end else if (i_action == ACT_ABORT) begin
                    o_total      = tot_leave;
                    o_mode       = MODE_IDLE;
                    o_set_time   = '0;
                    o_elapsed    = '0;
                    o_res.status = ST_MOVE;
                end
            end
            MODE_PAUSE: begin
                if (i_action == ACT_INC) begin
                    o_set_time   = set_inc;
                    o_mode       = MODE_SET;
                    o_res.status = ST_MOVE;
                end else if (i_action == ACT_DEC) begin
                    if (dec_ok) begin
                        o_set_time   = diff[TIME_BITS-1:0];
                        o_mode       = MODE_SET;
                        o_res.status = ST_MOVE;
                    end
                end
            end
            MODE_STAT: begin
                if (i_action == ACT_TICK) begin
                    o_stat_cnt = cnt_inc;
                    if (cnt_inc == i_hold) begin
                        o_stat_cnt   = '0;
                        o_mode       = MODE_IDLE;
                        o_set_time   = '0;
                        o_elapsed    = '0;
                        o_res.status = ST_MOVE;
                    end
                end
            end
            default: begin
                o_mode     = MODE_IDLE;
                o_set_time = '0;
                o_elapsed  = '0;
            end
        endcase

        o_res.mode = mode_code(o_mode);
        o_shown    = (o_mode == MODE_STAT) ? o_total : SHOWN_W'(o_set_time);
    end

endmodule

@@ sv/countdown_timer_controller.sv @@
// Countdown timer controller, five modes: idle, set, countdown, pause, statistics.
// Event words enter on the s_axis side (action in tuser, subsecond in tdata).
// Each accepted event yields exactly one result word on the m_axis side:
// mode, shown time (productive total in statistics, else set time), beep and
// event status.
// The result word is registered: it appears in the cycle after its event is accepted.
// Throughput: one event per cycle while m_axis does not stall; the state update and the result register
// are written in the same cycle the event is taken.
// The result register doubles as the output stage: s_axis_tready is high
// whenever it is empty or being drained, so a stall on m_axis holds the word
// and blocks only the next event.
// Configuration: i_cfg_we writes step_seconds (index 0) or stat_hold_ticks
// (index 1) from i_cfg_data; write only while no event is in flight.
// Reset (synchronous, active low): idle mode, all times and counters zero,
// step 60 s, statistics hold 30 ticks, no result pending.
// Depends on ctc_pkg, ctc_step and countdown_timer_controller_macros.svh.
module countdown_timer_controller #(
    parameter int TIME_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [ctc_pkg::STEP_W-1:0]    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [3:0] subsecond, [7:4] zero
    input  logic [ctc_pkg::IN_W-1:0]      s_axis_tdata,
    // [2:0] action
    input  logic [ctc_pkg::ACT_W-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [2:0] mode, [34:3] shown_time, [35] beep, [37:36] event_status, [39:38] zero
    output logic [ctc_pkg::OUT_W-1:0]     m_axis_tdata
);
    import ctc_pkg::*;

    logic [STEP_W-1:0]    r_step;
    logic [HOLD_W-1:0]    r_hold;
    t_mode                r_mode;
    logic [TIME_BITS-1:0] r_set_time;
    logic [TIME_BITS-1:0] r_elapsed;
    logic [31:0]          r_total;
    logic [HOLD_W-1:0]    r_stat_cnt;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    t_mode                n_mode;
    logic [TIME_BITS-1:0] n_set_time;
    logic [TIME_BITS-1:0] n_elapsed;
    logic [31:0]          n_total;
    logic [HOLD_W-1:0]    n_stat_cnt;
    logic [SHOWN_W-1:0]   n_shown;
    t_result              n_res;

    logic                 accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    ctc_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_mode      (r_mode),
        .i_set_time  (r_set_time),
        .i_elapsed   (r_elapsed),
        .i_total     (r_total),
        .i_stat_cnt  (r_stat_cnt),
        .i_action    (s_axis_tuser),
        .i_subsecond (s_axis_tdata[SUB_W-1:0]),
        .i_step      (r_step),
        .i_hold      (r_hold),
        .o_mode      (n_mode),
        .o_set_time  (n_set_time),
        .o_elapsed   (n_elapsed),
        .o_total     (n_total),
        .o_stat_cnt  (n_stat_cnt),
        .o_shown     (n_shown),
        .o_res       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_W'(60);
            r_hold <= HOLD_W'(30);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STEP: r_step <= i_cfg_data;
                CFG_HOLD: r_hold <= i_cfg_data[HOLD_W-1:0];
                default:  r_step <= r_step;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_set_time <= '0;
            r_elapsed  <= '0;
            r_total    <= '0;
            r_stat_cnt <= '0;
        end else if (accept) begin
            r_mode     <= n_mode;
            r_set_time <= n_set_time;
            r_elapsed  <= n_elapsed;
            r_total    <= n_total;
            r_stat_cnt <= n_stat_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // load the result word with the event; hold it while stalled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {2'b00, n_res.status, n_res.beep, n_shown, n_res.mode};
        end
    end

`include "countdown_timer_controller_macros.svh"

    `CTC_ASSERT_IMPL(a_no_overrun, i_clk, i_rst_n, accept, (!r_out_valid || m_axis_tready))
    `CTC_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, accept, r_out_valid)
    `CTC_ASSERT_IMPL(a_idle_clear, i_clk, i_rst_n, (r_mode == MODE_IDLE),
        (r_set_time == '0 && r_elapsed == '0))
    `CTC_ASSERT_IMPL(a_elapsed_only_counting, i_clk, i_rst_n, (r_mode != MODE_COUNT),
        (r_elapsed == '0))

endmodule

@@ tb/countdown_timer_controller_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for countdown_timer_controller: drives event words with random
// gaps and stalls, predicts every result word and compares it field by field.
// Depends on ctc_pkg and the countdown_timer_controller RTL.
module countdown_timer_controller_tb;
    import ctc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int N_PHASES     = 6;
    localparam logic [ACT_W-1:0] ACT_BAD_LO = ACT_TICK + 3'd1;
    localparam logic [ACT_W-1:0] ACT_BAD_HI = '1;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [SHOWN_W-1:0] shown;
        logic               beep;
        logic [STAT_W-1:0]  status;
    } t_timer_word;

    class t_timer_scoreboard;
        logic [STEP_W-1:0] step_cfg;
        logic [HOLD_W-1:0] hold_cfg;
        logic [MODE_W-1:0] mode;
        logic [15:0]       set_time;
        logic [15:0]       elapsed;
        logic [31:0]       total;
        logic [7:0]        stat_ticks;
        t_timer_word       pending[$];
        int                errors;
        int                events;
        int                moves;
        int                beeps;

        function new();
            step_cfg   = 12'd60;
            hold_cfg   = 8'd30;
            mode       = MC_IDLE;
            set_time   = '0;
            elapsed    = '0;
            total      = '0;
            stat_ticks = '0;
            errors     = 0;
            events     = 0;
            moves      = 0;
            beeps      = 0;
        endfunction

        function void write_cfg(input logic idx, input logic [STEP_W-1:0] data);
            if (idx == CFG_STEP) begin
                step_cfg = data;
            end else begin
                hold_cfg = data[HOLD_W-1:0];
            end
        endfunction

        function void add_step(input int unsigned stp);
            int unsigned sum;
            sum = set_time + stp;
            set_time = (sum > SET_LIMIT) ? 16'(SET_LIMIT) : 16'(sum);
        endfunction

        function void go_idle();
            mode     = MC_IDLE;
            set_time = '0;
            elapsed  = '0;
        endfunction

        // bank elapsed countdown seconds into the productive total, saturating
        function void bank_elapsed();
            logic [32:0] sum;
            sum = {1'b0, total} + elapsed;
            total = sum[32] ? '1 : sum[31:0];
            elapsed = '0;
        endfunction

        function void note_event(input logic [ACT_W-1:0] act, input logic [SUB_W-1:0] ss);
            t_timer_word  w;
            int unsigned  stp;
            w.beep   = 1'b0;
            w.status = ST_IGN;
            stp = (step_cfg == 0) ? 1 : step_cfg;
            case (mode)
                MC_IDLE: begin
                    if (act == ACT_INC) begin
                        add_step(stp);
                        mode = MC_SET;
                        w.status = ST_MOVE;
                    end else if (act == ACT_START) begin
                        mode = MC_STAT;
                        w.status = ST_MOVE;
                    end else if (act == ACT_TICK && ss == SUB_BEEP) begin
                        w.beep = 1'b1;
                        w.status = ST_DONE;
                    end
                end
                MC_SET: begin
                    if (act == ACT_INC) begin
                        add_step(stp);
                        w.status = ST_DONE;
                    end else if (act == ACT_DEC) begin
                        if (set_time >= stp) begin
                            set_time = set_time - 16'(stp);
                            w.status = ST_DONE;
                        end
                    end else if (act == ACT_START) begin
                        if (set_time >= stp) begin
                            mode = MC_COUNT;
                            w.status = ST_MOVE;
                        end
                    end else if (act == ACT_ABORT) begin
                        go_idle();
                        w.status = ST_MOVE;
                    end
                end
                MC_COUNT: begin
                    if (act == ACT_TICK) begin
                        if (ss == SUB_SEC) begin
                            if (set_time != 0) set_time = set_time - 16'd1;
                            if (elapsed != '1) elapsed = elapsed + 16'd1;
                            if (set_time == 0) begin
                                bank_elapsed();
                                go_idle();
                                w.status = ST_MOVE;
                            end else begin
                                w.status = ST_DONE;
                            end
                        end
                    end else if (act == ACT_START) begin
                        bank_elapsed();
                        mode = MC_PAUSE;
                        w.status = ST_MOVE;
                    end else if (act == ACT_ABORT) begin
                        bank_elapsed();
                        go_idle();
                        w.status = ST_MOVE;
                    end
                end
                MC_PAUSE: begin
                    if (act == ACT_INC) begin
                        add_step(stp);
                        mode = MC_SET;
                        w.status = ST_MOVE;
                    end else if (act == ACT_DEC && set_time >= stp) begin
                        set_time = set_time - 16'(stp);
                        mode = MC_SET;
                        w.status = ST_MOVE;
                    end
                end
                MC_STAT: begin
                    if (act == ACT_TICK) begin
                        stat_ticks = stat_ticks + 8'd1;
                        if (stat_ticks == hold_cfg) begin
                            stat_ticks = '0;
                            go_idle();
                            w.status = ST_MOVE;
                        end
                    end
                end
                default: go_idle();
            endcase
            w.mode  = mode;
            w.shown = (mode == MC_STAT) ? total : {16'd0, set_time};
            events++;
            if (w.status == ST_MOVE) moves++;
            if (w.beep) beeps++;
            pending.push_back(w);
        endfunction

        function void check_result(input logic [OUT_W-1:0] word);
            t_timer_word w;
            if (pending.size() == 0) begin
                $error("result word %h with no event waiting", word);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (word[2:0] !== w.mode) begin
                $error("mode: expected %0d, actual %0d", w.mode, word[2:0]);
                errors++;
            end
            if (word[34:3] !== w.shown) begin
                $error("shown_time: expected %0d, actual %0d", w.shown, word[34:3]);
                errors++;
            end
            if (word[35] !== w.beep) begin
                $error("beep: expected %0d, actual %0d", w.beep, word[35]);
                errors++;
            end
            if (word[37:36] !== w.status) begin
                $error("event_status: expected %0d, actual %0d", w.status, word[37:36]);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [STEP_W-1:0]  i_cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic [ACT_W-1:0]   s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;

    t_timer_scoreboard sb = new();
    int  cycles = 0;
    bit  send_burst = 1'b0;
    bit  recv_burst = 1'b0;

    countdown_timer_controller u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one event word: random gap, then hold until accepted
    task automatic send_event(input logic [ACT_W-1:0] act, input logic [SUB_W-1:0] ss);
        int gap;
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(IN_W - SUB_W){1'b0}}, ss};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_event(act, ss);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [STEP_W-1:0] stp, input logic [HOLD_W-1:0] hold);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_STEP;
        i_cfg_data <= stp;
        @(posedge i_clk);
        sb.write_cfg(CFG_STEP, stp);
        i_cfg_idx  <= CFG_HOLD;
        i_cfg_data <= {{(STEP_W - HOLD_W){1'b0}}, hold};
        @(posedge i_clk);
        sb.write_cfg(CFG_HOLD, {{(STEP_W - HOLD_W){1'b0}}, hold});
        i_cfg_we <= 1'b0;
    endtask

    // walk the timer back to idle with legal events
    task automatic bring_to_idle();
        while (sb.mode != MC_IDLE) begin
            case (sb.mode)
                MC_SET, MC_COUNT: send_event(ACT_ABORT, 4'($urandom_range(0, 15)));
                MC_PAUSE:         send_event(ACT_INC, 4'($urandom_range(0, 15)));
                default:          send_event(ACT_TICK, 4'($urandom_range(0, 15)));
            endcase
        end
    endtask

    // mostly events that the current mode handles, some noise
    function automatic void pick_event(output logic [ACT_W-1:0] act,
                                       output logic [SUB_W-1:0] ss);
        int r;
        r   = $urandom_range(0, 99);
        ss  = 4'($urandom_range(0, 15));
        act = 3'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
        case (sb.mode)
            MC_IDLE: begin
                if (r < 40) act = ACT_INC;
                else if (r < 52) act = ACT_START;
                else if (r < 80) begin
                    act = ACT_TICK;
                    if (r < 66) ss = SUB_BEEP;
                end
                else if (r < 86) act = ACT_DEC;
                else if (r < 92) act = ACT_ABORT;
            end
            MC_SET: begin
                if (r < 35) act = ACT_INC;
                else if (r < 60) act = ACT_DEC;
                else if (r < 82) act = ACT_START;
                else if (r < 87) act = ACT_ABORT;
                else if (r < 94) act = ACT_TICK;
            end
            MC_COUNT: begin
                if (r < 60) begin
                    act = ACT_TICK;
                    ss  = SUB_SEC;
                end
                else if (r < 70) act = ACT_TICK;
                else if (r < 85) act = ACT_START;
                else if (r < 93) act = ACT_ABORT;
                else if (r < 95) act = ACT_INC;
                else if (r < 97) act = ACT_DEC;
            end
            MC_PAUSE: begin
                if (r < 35) act = ACT_INC;
                else if (r < 70) act = ACT_DEC;
                else if (r < 78) act = ACT_START;
                else if (r < 85) act = ACT_ABORT;
                else if (r < 93) act = ACT_TICK;
            end
            default: begin
                if (r < 92) act = ACT_TICK;
                else if (r < 95) act = ACT_START;
                else if (r < 97) act = ACT_INC;
            end
        endcase
    endfunction

    // result side: random stall before each word, then check it
    initial begin
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            int stall;
            if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 16);
            repeat (stall) begin
                m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            sb.check_result(m_axis_tdata);
        end
    end

    initial begin
        static int unsigned phase_step[N_PHASES] = '{1, 3600, 0, 2, 4095, 5};
        static int unsigned phase_hold[N_PHASES] = '{3, 1, 2, 255, 0, 4};
        static int          phase_len[N_PHASES]  = '{90, 60, 80, 60, 50, 60};
        logic [ACT_W-1:0] act;
        logic [SUB_W-1:0] ss;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_STEP;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_INC;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk through every mode at the reset settings
        send_event(ACT_DEC, 4'hF);          // no handler in idle
        send_event(ACT_ABORT, 4'h0);
        send_event(ACT_TICK, SUB_BEEP);     // idle beep
        send_event(ACT_TICK, 4'hF);
        send_event(ACT_BAD_HI, 4'h0);       // unknown event
        send_event(ACT_INC, 4'h0);
        send_event(ACT_INC, 4'h3);
        send_event(ACT_DEC, 4'hC);
        send_event(ACT_DEC, 4'h0);          // down to zero
        send_event(ACT_DEC, 4'h0);          // below one step: ignored
        send_event(ACT_START, 4'h0);        // nothing set: ignored
        send_event(ACT_TICK, SUB_SEC);
        send_event(ACT_INC, 4'h0);
        send_event(ACT_START, 4'h0);
        send_event(ACT_TICK, SUB_SEC);
        send_event(ACT_TICK, 4'h3);
        send_event(ACT_INC, 4'h0);
        send_event(ACT_START, 4'h0);        // pause, bank one second
        send_event(ACT_START, 4'h0);        // start and abort do nothing in pause
        send_event(ACT_ABORT, 4'h0);
        send_event(ACT_DEC, 4'h0);
        send_event(ACT_INC, 4'h0);
        send_event(ACT_START, 4'h0);
        send_event(ACT_TICK, SUB_SEC);
        send_event(ACT_ABORT, 4'h0);
        send_event(ACT_START, 4'h0);        // statistics
        send_event(ACT_ABORT, 4'h0);

        for (int p = 0; p < N_PHASES; p++) begin
            bring_to_idle();
            wait_drained();
            set_config(STEP_W'(phase_step[p]), HOLD_W'(phase_hold[p]));
            // large steps: push the set time into its ceiling
            if (phase_step[p] >= 3600) begin
                repeat (18) send_event(ACT_INC, 4'($urandom_range(0, 15)));
            end
            for (int k = 0; k < phase_len[p]; k++) begin
                if ($urandom_range(0, 39) == 0) wait_drained();
                pick_event(act, ss);
                send_event(act, ss);
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d events over %0d step/hold settings plus reset defaults",
                 sb.events, N_PHASES);
        $display("  %0d mode changes, %0d beeps, productive total %0d s, %0d mismatches",
                 sb.moves, sb.beeps, sb.total, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
